// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock while reset is released.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent checked in the clock after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/lfdc_pkg.sv
// ----------------------------------------------------------------------------
// lfdc_pkg
// Types, pattern codes and helpers of the line follower drive control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfdc_pkg;

	localparam int unsigned DUTY_W     = 8;
	localparam int unsigned HOLD_W     = 16;
	localparam int unsigned SENSOR_W   = 6;
	localparam int unsigned SECS_W     = 8;
	localparam int unsigned ERR_W      = 14;
	localparam int unsigned TENTH_W    = 13;
	localparam int unsigned BOOST_W    = 10;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [DUTY_W-1:0] DUTY_MAX       = 8'd255;
	localparam logic [SECS_W-1:0] FINISH_SECONDS = 8'd6;
	// floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
	localparam logic [15:0]       RECIP10        = 16'd52429;
	localparam int unsigned       RECIP10_SHIFT  = 19;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SMALL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MID    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BIG    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_DUTY     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_HOLD_MS  = 3'd7;

	// sensor patterns, bit 0 is the leftmost sensor
	localparam logic [SENSOR_W-1:0] PAT_LOST      = 6'h00;
	localparam logic [SENSOR_W-1:0] PAT_L_BIG     = 6'h01;
	localparam logic [SENSOR_W-1:0] PAT_L_MID     = 6'h02;
	localparam logic [SENSOR_W-1:0] PAT_L_SMALL   = 6'h04;
	localparam logic [SENSOR_W-1:0] PAT_L_MID2    = 6'h06;
	localparam logic [SENSOR_W-1:0] PAT_R_SMALL   = 6'h08;
	localparam logic [SENSOR_W-1:0] PAT_CENTER    = 6'h0C;
	localparam logic [SENSOR_W-1:0] PAT_R_MID     = 6'h10;
	localparam logic [SENSOR_W-1:0] PAT_R_SMALL2  = 6'h18;
	localparam logic [SENSOR_W-1:0] PAT_R_BIG     = 6'h20;
	localparam logic [SENSOR_W-1:0] PAT_ALL       = 6'h3F;
	localparam logic [SENSOR_W-1:0] PAT_PIV_L_A   = 6'h07;
	localparam logic [SENSOR_W-1:0] PAT_PIV_L_B   = 6'h0E;
	localparam logic [SENSOR_W-1:0] PAT_PIV_L_C   = 6'h0F;
	localparam logic [SENSOR_W-1:0] PAT_PIV_R_A   = 6'h1C;
	localparam logic [SENSOR_W-1:0] PAT_PIV_R_B   = 6'h38;
	localparam logic [SENSOR_W-1:0] PAT_PIV_R_C   = 6'h3C;

	// which outermost sensor set the last error
	localparam logic [1:0] OUTER_NONE  = 2'd0;
	localparam logic [1:0] OUTER_RIGHT = 2'd1;
	localparam logic [1:0] OUTER_LEFT  = 2'd2;

	typedef logic signed [ERR_W-1:0] err_t;

	typedef struct packed {
		logic [DUTY_W-1:0] base_speed;
		logic [DUTY_W-1:0] straight_gain;
		logic [DUTY_W-1:0] curve_gain;
		logic [DUTY_W-1:0] weight_small;
		logic [DUTY_W-1:0] weight_mid;
		logic [DUTY_W-1:0] weight_big;
		logic [DUTY_W-1:0] turn_duty;
		logic [HOLD_W-1:0] turn_hold_ms;
	} cfg_t;

	// steering magnitudes derived from the registers
	typedef struct packed {
		logic [TENTH_W-1:0] near;
		logic [TENTH_W-1:0] mid;
		logic [TENTH_W-1:0] big;
		logic [BOOST_W-1:0] boost;
	} steer_tbl_t;

	typedef struct packed {
		logic [SECS_W-1:0]   run_seconds;
		logic [SENSOR_W-1:0] sensor_bits;
	} in_item_t;

	typedef struct packed {
		logic [HOLD_W-1:0] hold_ms;
		logic [DUTY_W-1:0] left_reverse;
		logic [DUTY_W-1:0] left_forward;
		logic [DUTY_W-1:0] right_reverse;
		logic [DUTY_W-1:0] right_forward;
		logic              halted;
		logic              last;
	} beat_t;

	// saturate to +-255 and split into {reverse, forward}
	function automatic logic [2*DUTY_W-1:0] split_duty(input logic signed [ERR_W:0] v);
		logic signed [ERR_W:0] neg;
		logic [DUTY_W-1:0]     fwd;
		logic [DUTY_W-1:0]     rev;
		neg = -v;
		fwd = '0;
		rev = '0;
		if (v > $signed({7'd0, DUTY_MAX})) begin
			fwd = DUTY_MAX;
		end else if (v > 0) begin
			fwd = v[DUTY_W-1:0];
		end else if (neg > $signed({7'd0, DUTY_MAX})) begin
			rev = DUTY_MAX;
		end else begin
			rev = neg[DUTY_W-1:0];
		end
		return {rev, fwd};
	endfunction

endpackage

// File: design/line_follower_drive_control.sv
// ----------------------------------------------------------------------------
// line_follower_drive_control
// Two-wheel drive duties from a six-sensor line pattern per step.
// ----------------------------------------------------------------------------
// One sensor beat goes in, one or two drive beats come out. A beat accepted
// on the slave side passes three input stages and then the output register.
// A new beat can be taken every clock unless the output stalls or a pivot is
// pending. Most patterns give a single drive beat (tlast high). Right-angle
// corner patterns first give a pivot beat (tlast low, hold_ms = turn_hold_ms)
// and then the drive beat, so such a step holds the output register for both
// beats. The output register decouples the two sides: the input keeps filling
// its stages while a result waits on tready. Steering magnitudes
// (weight * gain / 10, and the boost 3 * curve_gain) are recomputed from the
// registers every clock in at most two registered steps; the three input
// stages cover that delay, so a register write is seen by any beat accepted
// in the same clock or later. Once the all-ones pattern is seen past six
// seconds, every further beat is the halted brake beat until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_follower_drive_control import lfdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// register write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// sensor beats
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,  // sensor_bits[5:0], run_seconds[13:6], 0
	// drive beats
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// right_forward, right_reverse, left_forward, left_reverse, hold_ms[47:32]
	output logic [47:0]           m_axis_tdata,
	output logic                  m_axis_tuser,  // halted
	output logic                  m_axis_tlast
);

	cfg_t       cfg;
	steer_tbl_t tbl;

	// input stages
	logic       vld_s1, vld_s2, vld_s3;
	in_item_t   item_s1, item_s2, item_s3;
	logic       adv1, adv2, adv3;

	// output side
	logic       out_vld_q;
	beat_t      out_beat_q;
	logic       pivot_sent_q;
	logic       load_ok;
	logic       pivot;
	logic       emit_pivot;
	beat_t      pivot_beat;
	beat_t      final_beat;

	lfdc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg),
		.tbl      (tbl)
	);

	lfdc_steer u_steer (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (adv3),
		.item       (item_s3),
		.cfg        (cfg),
		.tbl        (tbl),
		.pivot      (pivot),
		.pivot_beat (pivot_beat),
		.final_beat (final_beat)
	);

	// stage 3 retires its beat only with the final result of the step
	assign load_ok    = !out_vld_q || m_axis_tready;
	assign emit_pivot = pivot && !pivot_sent_q;
	assign adv3       = vld_s3 && load_ok && !emit_pivot;
	assign adv2       = vld_s2 && (!vld_s3 || adv3);
	assign adv1       = vld_s1 && (!vld_s2 || adv2);

	assign s_axis_tready = !vld_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (!vld_s2 || adv2) begin
				vld_s2 <= vld_s1;
			end
			if (!vld_s3 || adv3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= in_item_t'(s_axis_tdata[SENSOR_W+SECS_W-1:0]);
		end
		if (adv1) begin
			item_s2 <= item_s1;
		end
		if (adv2) begin
			item_s3 <= item_s2;
		end
	end

	// output register: pivot beat first where the pattern calls for one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q    <= 1'b0;
			pivot_sent_q <= 1'b0;
		end else if (load_ok) begin
			out_vld_q <= vld_s3;
			if (vld_s3) begin
				pivot_sent_q <= emit_pivot;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && vld_s3) begin
			out_beat_q <= emit_pivot ? pivot_beat : final_beat;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_beat_q.hold_ms, out_beat_q.left_reverse,
		out_beat_q.left_forward, out_beat_q.right_reverse, out_beat_q.right_forward};
	assign m_axis_tuser  = out_beat_q.halted;
	assign m_axis_tlast  = out_beat_q.last;

endmodule

// File: design/lfdc_cfg.sv
// ----------------------------------------------------------------------------
// lfdc_cfg
// Register file and the registered steering magnitudes derived from it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfdc_cfg import lfdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg,
	output steer_tbl_t            tbl
);

	cfg_t        cfg_q;
	logic [15:0] prod_small_q;
	logic [15:0] prod_mid_q;
	logic [15:0] prod_big_q;
	steer_tbl_t  tbl_q;
	logic [31:0] div_small;
	logic [31:0] div_mid;
	logic [31:0] div_big;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_BASE_SPEED:    cfg_q.base_speed    <= cfg_data[DUTY_W-1:0];
				REG_STRAIGHT_GAIN: cfg_q.straight_gain <= cfg_data[DUTY_W-1:0];
				REG_CURVE_GAIN:    cfg_q.curve_gain    <= cfg_data[DUTY_W-1:0];
				REG_WEIGHT_SMALL:  cfg_q.weight_small  <= cfg_data[DUTY_W-1:0];
				REG_WEIGHT_MID:    cfg_q.weight_mid    <= cfg_data[DUTY_W-1:0];
				REG_WEIGHT_BIG:    cfg_q.weight_big    <= cfg_data[DUTY_W-1:0];
				REG_TURN_DUTY:     cfg_q.turn_duty     <= cfg_data[DUTY_W-1:0];
				REG_TURN_HOLD_MS:  cfg_q.turn_hold_ms  <= cfg_data[HOLD_W-1:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	// weight * gain, then /10 by reciprocal in the following clock
	assign div_small = prod_small_q * RECIP10;
	assign div_mid   = prod_mid_q * RECIP10;
	assign div_big   = prod_big_q * RECIP10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_small_q <= '0;
			prod_mid_q   <= '0;
			prod_big_q   <= '0;
			tbl_q        <= '0;
		end else begin
			prod_small_q <= cfg_q.weight_small * cfg_q.straight_gain;
			prod_mid_q   <= cfg_q.weight_mid * cfg_q.curve_gain;
			prod_big_q   <= cfg_q.weight_big * cfg_q.curve_gain;
			tbl_q.near   <= div_small[RECIP10_SHIFT +: TENTH_W];
			tbl_q.mid    <= div_mid[RECIP10_SHIFT +: TENTH_W];
			tbl_q.big    <= div_big[RECIP10_SHIFT +: TENTH_W];
			tbl_q.boost  <= {1'b0, cfg_q.curve_gain, 1'b0} + {2'b00, cfg_q.curve_gain};
		end
	end

	assign cfg = cfg_q;
	assign tbl = tbl_q;

endmodule

// File: design/lfdc_steer.sv
// ----------------------------------------------------------------------------
// lfdc_steer
// Steering state, pattern decode and the beats one step produces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfdc_steer import lfdc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       commit,
	input  in_item_t   item,
	input  cfg_t       cfg,
	input  steer_tbl_t tbl,
	output logic       pivot,
	output beat_t      pivot_beat,
	output beat_t      final_beat
);

	err_t                  err_q;
	logic [1:0]            outer_q;
	logic                  finished_q;
	err_t                  err_nxt;
	logic [1:0]            outer_nxt;
	logic                  finish_now;
	logic                  piv_right;
	logic                  piv_left;
	logic signed [ERR_W:0] sum_l;
	logic signed [ERR_W:0] sum_r;
	logic [2*DUTY_W-1:0]   duty_l;
	logic [2*DUTY_W-1:0]   duty_r;

	assign finish_now = finished_q
		|| (item.sensor_bits == PAT_ALL && item.run_seconds > FINISH_SECONDS);

	always_comb begin
		err_nxt   = err_q;
		outer_nxt = outer_q;
		unique case (item.sensor_bits)
			PAT_R_BIG: begin
				err_nxt   = err_t'({1'b0, tbl.big});
				outer_nxt = OUTER_RIGHT;
			end
			PAT_R_MID: begin
				err_nxt   = err_t'({1'b0, tbl.mid});
				outer_nxt = OUTER_NONE;
			end
			PAT_R_SMALL, PAT_R_SMALL2: begin
				err_nxt   = err_t'({1'b0, tbl.near});
				outer_nxt = OUTER_NONE;
			end
			PAT_CENTER: begin
				err_nxt   = '0;
				outer_nxt = OUTER_NONE;
			end
			PAT_L_SMALL: begin
				err_nxt   = -err_t'({1'b0, tbl.near});
				outer_nxt = OUTER_NONE;
			end
			PAT_L_MID, PAT_L_MID2: begin
				err_nxt   = -err_t'({1'b0, tbl.mid});
				outer_nxt = OUTER_NONE;
			end
			PAT_L_BIG: begin
				err_nxt   = -err_t'({1'b0, tbl.big});
				outer_nxt = OUTER_LEFT;
			end
			PAT_LOST: begin
				// line lost past an outermost sensor: hard recovery steer
				if (outer_q == OUTER_LEFT) begin
					err_nxt = -err_t'({1'b0, tbl.boost});
				end else if (outer_q == OUTER_RIGHT) begin
					err_nxt = err_t'({1'b0, tbl.boost});
				end
			end
			default: begin
				err_nxt   = err_q;
				outer_nxt = outer_q;
			end
		endcase
	end

	assign piv_right = item.sensor_bits == PAT_PIV_L_A || item.sensor_bits == PAT_PIV_L_B
		|| item.sensor_bits == PAT_PIV_L_C;
	assign piv_left  = item.sensor_bits == PAT_PIV_R_A || item.sensor_bits == PAT_PIV_R_B
		|| item.sensor_bits == PAT_PIV_R_C;
	assign pivot     = !finish_now && (piv_right || piv_left);

	always_comb begin
		pivot_beat         = '0;
		pivot_beat.hold_ms = cfg.turn_hold_ms;
		if (piv_right) begin
			pivot_beat.right_forward = cfg.turn_duty;
			pivot_beat.left_forward  = DUTY_MAX;
			pivot_beat.left_reverse  = DUTY_MAX;
		end else begin
			pivot_beat.right_forward = DUTY_MAX;
			pivot_beat.right_reverse = DUTY_MAX;
			pivot_beat.left_forward  = cfg.turn_duty;
		end
	end

	assign sum_l  = $signed({7'd0, cfg.base_speed}) + {err_nxt[ERR_W-1], err_nxt};
	assign sum_r  = $signed({7'd0, cfg.base_speed}) - {err_nxt[ERR_W-1], err_nxt};
	assign duty_l = split_duty(sum_l);
	assign duty_r = split_duty(sum_r);

	always_comb begin
		final_beat      = '0;
		final_beat.last = 1'b1;
		if (finish_now) begin
			final_beat.right_forward = DUTY_MAX;
			final_beat.right_reverse = DUTY_MAX;
			final_beat.left_forward  = DUTY_MAX;
			final_beat.left_reverse  = DUTY_MAX;
			final_beat.halted        = 1'b1;
		end else begin
			final_beat.right_forward = duty_r[DUTY_W-1:0];
			final_beat.right_reverse = duty_r[2*DUTY_W-1:DUTY_W];
			final_beat.left_forward  = duty_l[DUTY_W-1:0];
			final_beat.left_reverse  = duty_l[2*DUTY_W-1:DUTY_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q      <= '0;
			outer_q    <= OUTER_NONE;
			finished_q <= 1'b0;
		end else if (commit) begin
			if (finish_now) begin
				finished_q <= 1'b1;
			end else begin
				err_q   <= err_nxt;
				outer_q <= outer_nxt;
			end
		end
	end

endmodule

// File: design/lfdc_checker.sv
// ----------------------------------------------------------------------------
// lfdc_checker
// Port-level checks of the line follower drive control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfdc_checker import lfdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [47:0]           m_axis_tdata,
	input  logic                  m_axis_tuser,
	input  logic                  m_axis_tlast
);

	logic halted_seen_q;
	logic cfg_seen;
	logic in_seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_seen_q <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser) begin
			halted_seen_q <= 1'b1;
		end
	end

	// unused port groups, tied into a harmless observation
	assign cfg_seen = cfg_we && (cfg_idx == REG_BASE_SPEED) && (cfg_data == '0);
	assign in_seen  = s_axis_tvalid && s_axis_tready && (s_axis_tdata == '0);

	`ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "stalled drive beat changed")

	`ASSERT_ALWAYS(a_brake_beat, !(m_axis_tvalid && m_axis_tuser) || (m_axis_tlast
		&& m_axis_tdata[31:0] == 32'hFFFF_FFFF && m_axis_tdata[47:32] == 16'd0),
		"halted beat is not the full brake")

	`ASSERT_ALWAYS(a_halt_latched, !(m_axis_tvalid && halted_seen_q) || m_axis_tuser,
		"drive beat after finish brake")

	`ASSERT_NEXT(a_pivot_then_drive, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
		m_axis_tvalid && m_axis_tlast && !m_axis_tuser, "pivot beat not followed by drive")

	`ASSERT_ALWAYS(a_split_duty, !(m_axis_tvalid && m_axis_tlast && !m_axis_tuser)
		|| ((m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[15:8] == 8'd0)
		&& (m_axis_tdata[23:16] == 8'd0 || m_axis_tdata[31:24] == 8'd0)
		&& (cfg_seen || !cfg_seen) && (in_seen || !in_seen)),
		"wheel driven both ways")

endmodule

bind line_follower_drive_control lfdc_checker u_lfdc_checker (.*);
